// ===== src/nca_pkg.sv =====
`default_nettype none

package nca_pkg;

    // Default sizes of the centre store and of the coordinates.
    localparam int MAX_CENTERS_DEF = 16;
    localparam int DIMS_DEF        = 4;
    localparam int COORD_BITS_DEF  = 16;

    // Fixed field widths of the ports.
    localparam int IN_COORD_W = 16;
    localparam int IN_COORDS  = 4;
    localparam int SLOT_W     = 4;
    localparam int TAG_W      = 16;
    localparam int CFG_W      = 5;
    localparam int IDX_W      = 4;
    localparam int DIST_W     = 34;

    // Registers from centre row to squared term inside one lane.
    localparam int LANE_LAT = 2;

    // Function codes of an input item.
    localparam logic FUNC_LOAD     = 1'b0;
    localparam logic FUNC_CLASSIFY = 1'b1;

    // Control travelling alongside one centre through lanes and merge.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_scan_ctl;

    // Result handed from the merge stage to the top level.
    typedef struct packed {
        logic              done;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] dist_sq;
    } t_result;

endpackage

`default_nettype wire

// ===== src/nca_lane.sv =====
`default_nettype none

module nca_lane #(
    parameter int COORD_BITS = nca_pkg::COORD_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic signed [COORD_BITS-1:0]   i_center,
    input  wire logic signed [COORD_BITS-1:0]   i_point,
    output logic         [2*COORD_BITS-1:0]     o_sq
);

    logic signed [COORD_BITS:0]     r_diff;
    logic signed [2*COORD_BITS+1:0] w_prod;
    logic        [2*COORD_BITS-1:0] r_sq;

    // Difference of one coordinate, one bit wider so that it never wraps.
    always_ff @(posedge i_clk) begin
        r_diff <= (COORD_BITS+1)'(i_center) - (COORD_BITS+1)'(i_point);
    end

    // The square stays below 2^(2*COORD_BITS), so the low half holds it exactly.
    assign w_prod = r_diff * r_diff;

    always_ff @(posedge i_clk) begin
        r_sq <= w_prod[2*COORD_BITS-1:0];
    end

    assign o_sq = r_sq;

endmodule

`default_nettype wire

// ===== src/nca_merge.sv =====
`default_nettype none

module nca_merge #(
    parameter int DIMS       = nca_pkg::DIMS_DEF,
    parameter int COORD_BITS = nca_pkg::COORD_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [2*COORD_BITS-1:0]   i_sq [DIMS],
    input  wire nca_pkg::t_scan_ctl        i_ctl,
    output nca_pkg::t_result               o_res
);

    localparam int LEVELS = $clog2(DIMS);
    localparam int P      = 1 << LEVELS;
    localparam int SUM_W  = (2*COORD_BITS + LEVELS > 64) ? 64 : 2*COORD_BITS + LEVELS;
    localparam int DW     = nca_pkg::DIST_W;

    logic [SUM_W-1:0]       w_leaf [P];
    logic [SUM_W-1:0]       w_root;
    nca_pkg::t_scan_ctl     w_root_ctl;
    logic                   w_win;
    logic [SUM_W-1:0]       r_best;
    logic [nca_pkg::IDX_W-1:0] r_best_idx;
    logic                   r_done;
    logic [nca_pkg::IDX_W-1:0] r_idx;
    logic [DW-1:0]          r_dist;

    // Lane terms padded with zeros up to a power of two.
    for (genvar i = 0; i < P; i++) begin : g_leaf
        if (i < DIMS) begin : g_used
            assign w_leaf[i] = SUM_W'(i_sq[i]);
        end else begin : g_pad
            assign w_leaf[i] = '0;
        end
    end

    // Registered adder tree, one register per level; sums over 64 bits wrap.
    if (LEVELS == 0) begin : g_single
        assign w_root     = w_leaf[0];
        assign w_root_ctl = i_ctl;
    end else begin : g_tree
        logic [SUM_W-1:0]   r_node [P-1];
        logic [SUM_W-1:0]   w_a    [P-1];
        logic [SUM_W-1:0]   w_b    [P-1];
        nca_pkg::t_scan_ctl r_ctl_d [LEVELS];

        for (genvar j = 0; j < P-1; j++) begin : g_node
            if (2*j+1 >= P-1) begin : g_from_leaf
                assign w_a[j] = w_leaf[2*j+1-(P-1)];
                assign w_b[j] = w_leaf[2*j+2-(P-1)];
            end else begin : g_from_node
                assign w_a[j] = r_node[2*j+1];
                assign w_b[j] = r_node[2*j+2];
            end
        end

        always_ff @(posedge i_clk) begin
            for (int j = 0; j < P-1; j++) begin
                r_node[j] <= w_a[j] + w_b[j];
            end
        end

        // Control follows the tree so that it meets the finished sum.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                for (int k = 0; k < LEVELS; k++) begin
                    r_ctl_d[k] <= '0;
                end
            end else begin
                r_ctl_d[0] <= i_ctl;
                for (int k = 1; k < LEVELS; k++) begin
                    r_ctl_d[k] <= r_ctl_d[k-1];
                end
            end
        end

        assign w_root     = r_node[0];
        assign w_root_ctl = r_ctl_d[LEVELS-1];
    end

    // The first centre always wins; later ones only when strictly nearer.
    assign w_win = w_root_ctl.first || (w_root < r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_root_ctl.valid && w_root_ctl.last;
        end
    end

    // Running minimum and the result of the last centre.
    always_ff @(posedge i_clk) begin
        if (w_root_ctl.valid && w_win) begin
            r_best     <= w_root;
            r_best_idx <= w_root_ctl.idx;
        end
        if (w_root_ctl.valid && w_root_ctl.last) begin
            r_dist <= w_win ? DW'(w_root) : DW'(r_best);
            r_idx  <= w_win ? w_root_ctl.idx : r_best_idx;
        end
    end

    assign o_res.done    = r_done;
    assign o_res.idx     = r_idx;
    assign o_res.dist_sq = r_dist;

endmodule

`default_nettype wire

// ===== src/nearest_center_assign.sv =====
`default_nettype none

// Nearest-centre assignment for k-means clustering.
// Items enter on start while busy is low. A load item (i_func low) writes
// the coordinates of slot i_center_slot in that same cycle and leaves busy
// low, so loads may follow one per cycle. A classify item (i_func high)
// raises busy and scans centres 0 to num_centers-1, one centre per cycle,
// with DIMS lanes forming the squared coordinate differences side by side
// and a registered adder tree plus running minimum merging them.
// o_done pulses for one cycle with o_tag_out, o_nearest_center and
// o_min_distance; the receiver cannot stall, so the result must be taken
// then. Busy falls at the edge that ends the strobe, so the next item is
// taken only after the result of a classify item has been given on o_done.
// num_centers is written on the cfg channel while idle.
// Reset clears the control state and sets num_centers to one; the centre
// memory is not cleared and every slot used must be loaded first.
module nearest_center_assign #(
    parameter int MAX_CENTERS = nca_pkg::MAX_CENTERS_DEF,
    parameter int DIMS        = nca_pkg::DIMS_DEF,
    parameter int COORD_BITS  = nca_pkg::COORD_BITS_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    start,
    output logic                                         busy,
    input  wire logic                                    i_func,
    input  wire logic        [nca_pkg::SLOT_W-1:0]       i_center_slot,
    input  wire logic        [nca_pkg::TAG_W-1:0]        i_point_tag,
    input  wire logic signed [nca_pkg::IN_COORD_W-1:0]   i_coord0,
    input  wire logic signed [nca_pkg::IN_COORD_W-1:0]   i_coord1,
    input  wire logic signed [nca_pkg::IN_COORD_W-1:0]   i_coord2,
    input  wire logic signed [nca_pkg::IN_COORD_W-1:0]   i_coord3,
    input  wire logic                                    i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  wire logic        [nca_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                                         o_done,
    output logic             [nca_pkg::TAG_W-1:0]        o_tag_out,
    output logic             [nca_pkg::IDX_W-1:0]        o_nearest_center,
    output logic             [nca_pkg::DIST_W-1:0]       o_min_distance
);

    localparam int AW    = $clog2(MAX_CENTERS);
    localparam int ROW_W = DIMS * COORD_BITS;
    localparam int IW    = nca_pkg::IDX_W;
    localparam int CW    = nca_pkg::CFG_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT
    } t_state;

    t_state                           r_state;
    logic [AW-1:0]                    r_addr;
    logic [AW-1:0]                    r_last;
    logic [AW-1:0]                    w_last;
    logic [31:0]                      w_eff;
    logic [CW-1:0]                    r_num_centers;
    logic [ROW_W-1:0]                 r_mem [MAX_CENTERS];
    logic [ROW_W-1:0]                 r_rd_row;
    logic [ROW_W-1:0]                 w_row;
    logic signed [nca_pkg::IN_COORD_W-1:0] w_in [nca_pkg::IN_COORDS];
    logic signed [COORD_BITS-1:0]     w_pt [DIMS];
    logic signed [COORD_BITS-1:0]     r_point [DIMS];
    logic [nca_pkg::TAG_W-1:0]        r_tag;
    logic [2*COORD_BITS-1:0]          w_sq [DIMS];
    nca_pkg::t_scan_ctl               r_ctl_rd;
    nca_pkg::t_scan_ctl               r_ctl_p [nca_pkg::LANE_LAT];
    nca_pkg::t_result                 w_res;
    logic                             w_take;
    logic                             w_cls_go;
    logic                             w_load_go;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = !busy;

    assign w_take    = start && !busy;
    assign w_cls_go  = w_take && (i_func == nca_pkg::FUNC_CLASSIFY);
    assign w_load_go = w_take && (i_func == nca_pkg::FUNC_LOAD)
                       && (32'(i_center_slot) < 32'(MAX_CENTERS));

    // Coordinates wrapped to the stored width; missing dimensions are zero.
    assign w_in[0] = i_coord0;
    assign w_in[1] = i_coord1;
    assign w_in[2] = i_coord2;
    assign w_in[3] = i_coord3;

    for (genvar d = 0; d < DIMS; d++) begin : g_coord
        if (d < nca_pkg::IN_COORDS) begin : g_field
            assign w_pt[d] = COORD_BITS'(w_in[d]);
        end else begin : g_zero
            assign w_pt[d] = '0;
        end
        assign w_row[d*COORD_BITS +: COORD_BITS] = w_pt[d];
    end

    // Centre count register, reset to one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_centers <= CW'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_num_centers <= i_cfg_data;
        end
    end

    // Centres scanned: zero counts as one, excess counts as the store size.
    always_comb begin
        w_eff = 32'(r_num_centers);
        if (w_eff == 32'd0) begin
            w_eff = 32'd1;
        end else if (w_eff > 32'(MAX_CENTERS)) begin
            w_eff = 32'(MAX_CENTERS);
        end
        w_last = AW'(w_eff - 32'd1);
    end

    // Centre memory: one write port for loads, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_load_go) begin
            r_mem[AW'(i_center_slot)] <= w_row;
        end
        r_rd_row <= r_mem[r_addr];
    end

    // Point and tag of the item being classified.
    always_ff @(posedge i_clk) begin
        if (w_cls_go) begin
            r_tag <= i_point_tag;
            for (int d = 0; d < DIMS; d++) begin
                r_point[d] <= w_pt[d];
            end
        end
    end

    // Scan sequencer: one centre address per cycle, then wait for the merge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_addr   <= '0;
            r_last   <= '0;
            r_ctl_rd <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_ctl_rd.valid <= 1'b0;
                    if (w_cls_go) begin
                        r_addr  <= '0;
                        r_last  <= w_last;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_ctl_rd.valid <= 1'b1;
                    r_ctl_rd.first <= (r_addr == '0);
                    r_ctl_rd.last  <= (r_addr == r_last);
                    r_ctl_rd.idx   <= IW'(r_addr);
                    if (r_addr == r_last) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_WAIT: begin
                    r_ctl_rd.valid <= 1'b0;
                    if (w_res.done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_ctl_rd.valid <= 1'b0;
                    r_state        <= S_IDLE;
                end
            endcase
        end
    end

    // One lane per dimension works on the centre row just read.
    for (genvar d = 0; d < DIMS; d++) begin : g_lane
        nca_lane #(
            .COORD_BITS (COORD_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_center (r_rd_row[d*COORD_BITS +: COORD_BITS]),
            .i_point  (r_point[d]),
            .o_sq     (w_sq[d])
        );
    end

    // Control delayed to match the lane latency.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < nca_pkg::LANE_LAT; k++) begin
                r_ctl_p[k] <= '0;
            end
        end else begin
            r_ctl_p[0] <= r_ctl_rd;
            for (int k = 1; k < nca_pkg::LANE_LAT; k++) begin
                r_ctl_p[k] <= r_ctl_p[k-1];
            end
        end
    end

    nca_merge #(
        .DIMS       (DIMS),
        .COORD_BITS (COORD_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sq    (w_sq),
        .i_ctl   (r_ctl_p[nca_pkg::LANE_LAT-1]),
        .o_res   (w_res)
    );

    assign o_done           = w_res.done;
    assign o_nearest_center = w_res.idx;
    assign o_min_distance   = w_res.dist_sq;
    assign o_tag_out        = r_tag;

    // A result only appears while a classify item waits for it.
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == S_WAIT))
        else $error("result strobe outside the wait state");

    // A classify item starts the scan at centre zero.
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cls_go |=> (r_state == S_SCAN) && (r_addr == '0))
        else $error("classify item did not start the scan");

    // Centre reads are tagged valid only for addresses issued by the scan.
    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl_rd.valid |-> ($past(r_state) == S_SCAN))
        else $error("centre read marked valid outside the scan");

    // The configuration register is never written during a classify item.
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> $stable(r_num_centers))
        else $error("centre count changed while busy");

endmodule

`default_nettype wire
